### rtl/sddw_pkg.sv
// ----------------------------------------------------------------------------
// sddw_pkg
// Shared types, constants and the microcode table of the signed decimal
// digit writer.
// ----------------------------------------------------------------------------
package sddw_pkg;

    localparam int MAX_DIGITS = 8;
    localparam int NUM_BITS   = 32;
    localparam int NUM_BCD    = 10;
    localparam int CNT_W      = $clog2(NUM_BITS + 1);
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 8;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_DIGITS_IN_USE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLANK_CODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MINUS_CODE    = 2'd2;

    localparam logic [ADDR_W-1:0] DIGITS_RESET = 4'd8;
    localparam logic [DATA_W-1:0] BLANK_RESET  = 8'd15;
    localparam logic [DATA_W-1:0] MINUS_RESET  = 8'd10;

    typedef logic [3:0] pc_t;

    typedef enum logic [2:0] {
        EMIT_NONE,
        EMIT_BLANK,
        EMIT_ZERO,
        EMIT_DIGIT,
        EMIT_SIGN
    } emit_t;

    typedef enum logic [2:0] {
        ADDR_HOLD,
        ADDR_LOAD_N,
        ADDR_LOAD_ONE,
        ADDR_DEC,
        ADDR_INC
    } addr_op_t;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_IN,
        COND_CNT_MORE,
        COND_ADDR_MORE,
        COND_NONZERO,
        COND_DIGIT_MORE,
        COND_NO_SIGN
    } cond_t;

    typedef struct packed {
        logic     accept;
        logic     shift;
        logic     prep;
        emit_t    emit;
        addr_op_t addr_op;
        cond_t    cond;
        pc_t      target;
    } uword_t;

    // Control handed from the sequencer to the datapath for the current step.
    typedef struct packed {
        logic     accept;
        logic     shift;
        logic     prep;
        emit_t    emit;
        addr_op_t addr_op;
        logic     fire;
    } ctrl_t;

    // Flags the datapath reports back for jump decisions and stalls.
    typedef struct packed {
        logic cnt_more;
        logic addr_more;
        logic nonzero;
        logic digit_more;
        logic no_sign;
        logic out_free;
    } status_t;

    localparam pc_t PC_IDLE      = 4'd0;
    localparam pc_t PC_CONV      = 4'd1;
    localparam pc_t PC_PREP      = 4'd2;
    localparam pc_t PC_BLANK     = 4'd3;
    localparam pc_t PC_ZERO_CHK  = 4'd4;
    localparam pc_t PC_ZERO      = 4'd5;
    localparam pc_t PC_DIGIT     = 4'd6;
    localparam pc_t PC_SIGN_CHK  = 4'd7;
    localparam pc_t PC_SIGN      = 4'd8;

    // When the condition holds the program jumps to target, else it falls
    // through to the next step.
    function automatic uword_t ucode_rom(pc_t pc);
        uword_t w;
        w = '{accept: 1'b0, shift: 1'b0, prep: 1'b0, emit: EMIT_NONE,
              addr_op: ADDR_HOLD, cond: COND_ALWAYS, target: PC_IDLE};
        case (pc)
            PC_IDLE: begin
                w.accept = 1'b1;
                w.cond   = COND_NO_IN;
                w.target = PC_IDLE;
            end
            PC_CONV: begin
                w.shift  = 1'b1;
                w.cond   = COND_CNT_MORE;
                w.target = PC_CONV;
            end
            PC_PREP: begin
                w.prep    = 1'b1;
                w.addr_op = ADDR_LOAD_N;
                w.cond    = COND_NEVER;
            end
            PC_BLANK: begin
                w.emit    = EMIT_BLANK;
                w.addr_op = ADDR_DEC;
                w.cond    = COND_ADDR_MORE;
                w.target  = PC_BLANK;
            end
            PC_ZERO_CHK: begin
                w.addr_op = ADDR_LOAD_ONE;
                w.cond    = COND_NONZERO;
                w.target  = PC_DIGIT;
            end
            PC_ZERO: begin
                w.emit   = EMIT_ZERO;
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
            PC_DIGIT: begin
                w.emit    = EMIT_DIGIT;
                w.addr_op = ADDR_INC;
                w.cond    = COND_DIGIT_MORE;
                w.target  = PC_DIGIT;
            end
            PC_SIGN_CHK: begin
                w.cond   = COND_NO_SIGN;
                w.target = PC_IDLE;
            end
            PC_SIGN: begin
                w.emit   = EMIT_SIGN;
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
            default: begin
                w.cond   = COND_ALWAYS;
                w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

### rtl/sddw_useq.sv
// ----------------------------------------------------------------------------
// sddw_useq
// Microcode sequencer: step counter, control table lookup and conditional
// jumps. Emit steps hold while the result register is occupied.
// ----------------------------------------------------------------------------
module sddw_useq
    import sddw_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    input  status_t status,
    output ctrl_t   ctrl
);

    pc_t    pc_reg;
    pc_t    pc_next;
    uword_t word;
    logic   stall;
    logic   taken;

    assign word  = ucode_rom(pc_reg);
    assign stall = (word.emit != EMIT_NONE) && !status.out_free;

    always_comb begin
        case (word.cond)
            COND_NEVER:      taken = 1'b0;
            COND_ALWAYS:     taken = 1'b1;
            COND_NO_IN:      taken = !s_valid;
            COND_CNT_MORE:   taken = status.cnt_more;
            COND_ADDR_MORE:  taken = status.addr_more;
            COND_NONZERO:    taken = status.nonzero;
            COND_DIGIT_MORE: taken = status.digit_more;
            COND_NO_SIGN:    taken = status.no_sign;
            default:         taken = 1'b0;
        endcase

        if (stall) begin
            pc_next = pc_reg;
        end else if (taken) begin
            pc_next = word.target;
        end else begin
            pc_next = pc_reg + 4'd1;
        end

        ctrl.accept  = word.accept;
        ctrl.shift   = word.shift;
        ctrl.prep    = word.prep;
        ctrl.emit    = word.emit;
        ctrl.addr_op = word.addr_op;
        ctrl.fire    = !stall;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

### rtl/sddw_dp.sv
// ----------------------------------------------------------------------------
// sddw_dp
// Datapath: shift-and-add-3 binary to BCD converter, digit count, address
// counter and the result register.
// ----------------------------------------------------------------------------
module sddw_dp
    import sddw_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ctrl_t                ctrl,
    input  logic                 s_valid,
    input  logic signed [31:0]   s_number,
    input  logic [ADDR_W-1:0]    n_eff,
    input  logic [DATA_W-1:0]    blank_code,
    input  logic [DATA_W-1:0]    minus_code,
    output status_t              status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ADDR_W-1:0]    m_reg_addr,
    output logic [DATA_W-1:0]    m_reg_data,
    output logic                 m_overflow,
    output logic                 m_last
);

    logic [NUM_BITS-1:0]         mag_reg;
    logic [NUM_BCD-1:0][3:0]     bcd_reg;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        neg_reg;
    logic [ADDR_W-1:0]           ndig_reg;
    logic [ADDR_W-1:0]           addr_reg;

    logic                        m_valid_reg;
    logic                        m_valid_next;
    logic [ADDR_W-1:0]           addr_out_reg;
    logic [DATA_W-1:0]           data_out_reg;
    logic                        ovf_out_reg;
    logic                        last_out_reg;

    logic [NUM_BCD-1:0][3:0]     adj;
    logic [ADDR_W-1:0]           ndig_calc;
    logic [ADDR_W-1:0]           dlim;
    logic                        sign_fits;
    logic                        dropped;
    logic [ADDR_W-1:0]           dig_idx;
    logic [DATA_W-1:0]           emit_data;
    logic                        emit_last;
    logic                        load;
    logic                        emit_fire;

    assign load      = ctrl.accept && s_valid;
    assign emit_fire = ctrl.fire && (ctrl.emit != EMIT_NONE);

    // Add 3 to every digit of five or more before the shift.
    always_comb begin
        for (int i = 0; i < NUM_BCD; i++) begin
            adj[i] = (bcd_reg[i] >= 4'd5) ? (bcd_reg[i] + 4'd3) : bcd_reg[i];
        end
    end

    // Count of significant digits: position of the top nonzero digit.
    always_comb begin
        ndig_calc = '0;
        for (int i = 0; i < NUM_BCD; i++) begin
            if (bcd_reg[i] != 4'd0) begin
                ndig_calc = ADDR_W'(i + 1);
            end
        end
    end

    assign dlim      = (ndig_reg < n_eff) ? ndig_reg : n_eff;
    assign sign_fits = neg_reg && (ndig_reg < n_eff);
    assign dropped   = (ndig_reg > n_eff) || (neg_reg && !(ndig_reg < n_eff));
    assign dig_idx   = addr_reg - 4'd1;

    always_comb begin
        case (ctrl.emit)
            EMIT_BLANK: begin
                emit_data = blank_code;
                emit_last = 1'b0;
            end
            EMIT_ZERO: begin
                emit_data = '0;
                emit_last = 1'b1;
            end
            EMIT_DIGIT: begin
                emit_data = {4'd0, bcd_reg[dig_idx]};
                emit_last = (addr_reg == dlim) && !sign_fits;
            end
            EMIT_SIGN: begin
                emit_data = minus_code;
                emit_last = 1'b1;
            end
            default: begin
                emit_data = '0;
                emit_last = 1'b0;
            end
        endcase
    end

    always_comb begin
        status.cnt_more   = (cnt_reg != CNT_W'(1));
        status.addr_more  = (addr_reg != 4'd1);
        status.nonzero    = (ndig_reg != 4'd0);
        status.digit_more = (addr_reg != dlim);
        status.no_sign    = !sign_fits;
        status.out_free   = !m_valid_reg || m_ready;
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (emit_fire) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            neg_reg <= s_number[31];
            mag_reg <= s_number[31] ? (~s_number + 32'd1) : s_number;
            bcd_reg <= '0;
            cnt_reg <= CNT_W'(NUM_BITS);
        end else if (ctrl.fire && ctrl.shift) begin
            {bcd_reg, mag_reg} <= {adj, mag_reg} << 1;
            cnt_reg <= cnt_reg - CNT_W'(1);
        end

        if (ctrl.fire && ctrl.prep) begin
            ndig_reg <= ndig_calc;
        end

        if (ctrl.fire) begin
            case (ctrl.addr_op)
                ADDR_LOAD_N:   addr_reg <= n_eff;
                ADDR_LOAD_ONE: addr_reg <= 4'd1;
                ADDR_DEC:      addr_reg <= addr_reg - 4'd1;
                ADDR_INC:      addr_reg <= addr_reg + 4'd1;
                default:       addr_reg <= addr_reg;
            endcase
        end

        if (emit_fire) begin
            addr_out_reg <= (ctrl.emit == EMIT_ZERO) ? 4'd1 : addr_reg;
            data_out_reg <= emit_data;
            last_out_reg <= emit_last;
            ovf_out_reg  <= emit_last && dropped;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_reg_addr = addr_out_reg;
    assign m_reg_data = data_out_reg;
    assign m_overflow = ovf_out_reg;
    assign m_last     = last_out_reg;

endmodule

### rtl/signed_decimal_digit_writer.sv
// ----------------------------------------------------------------------------
// signed_decimal_digit_writer
// Turns a signed 32-bit number into digit register writes for a display
// driver: blanks, decimal digits least significant first, then a minus sign.
// ----------------------------------------------------------------------------
//   channel   ports                                  moves
//   s_        s_valid s_ready s_number               one number per item
//   m_        m_valid m_ready m_reg_addr m_reg_data  one register write per item
//             m_overflow m_last
//   cfg_      cfg_we cfg_index cfg_wdata             register writes, no wait
//
// An item runs through the accept step, the 32 shift steps of the BCD
// converter, a digit count step, a blank write for each active digit and a
// zero check, then a single zero or the digit writes, a sign check and the
// sign write; a new number is taken only back at the idle step.
// Reset is synchronous, active low, and restores the register defaults.
// A stalled m_ready holds the sequencer on its current write.
// ----------------------------------------------------------------------------
module signed_decimal_digit_writer
    import sddw_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic signed [31:0]    s_number,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [ADDR_W-1:0]     m_reg_addr,
    output logic [DATA_W-1:0]     m_reg_data,
    output logic                  m_overflow,
    output logic                  m_last,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [DATA_W-1:0]     cfg_wdata
);

    logic [ADDR_W-1:0] digits_reg;
    logic [DATA_W-1:0] blank_reg;
    logic [DATA_W-1:0] minus_reg;
    logic [ADDR_W-1:0] n_eff;
    ctrl_t             ctrl;
    status_t           status;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            digits_reg <= DIGITS_RESET;
            blank_reg  <= BLANK_RESET;
            minus_reg  <= MINUS_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_DIGITS_IN_USE: digits_reg <= cfg_wdata[ADDR_W-1:0];
                CFG_BLANK_CODE:    blank_reg  <= cfg_wdata;
                CFG_MINUS_CODE:    minus_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // A digit count of zero acts as one; above the display size it saturates.
    always_comb begin
        if (digits_reg == 4'd0) begin
            n_eff = 4'd1;
        end else if (digits_reg > ADDR_W'(MAX_DIGITS)) begin
            n_eff = ADDR_W'(MAX_DIGITS);
        end else begin
            n_eff = digits_reg;
        end
    end

    assign s_ready = ctrl.accept;

    sddw_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .ctrl    (ctrl)
    );

    sddw_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .s_valid    (s_valid),
        .s_number   (s_number),
        .n_eff      (n_eff),
        .blank_code (blank_reg),
        .minus_code (minus_reg),
        .status     (status),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_reg_addr (m_reg_addr),
        .m_reg_data (m_reg_data),
        .m_overflow (m_overflow),
        .m_last     (m_last)
    );

endmodule
